// ===== rtl/core/plsu_pkg.sv =====
// shared types, codes and defaults of the positional list store
package plsu_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int MODE_W      = 4;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 7;
   localparam int STATUS_W    = 3;
   localparam int FOUND_W     = 7;
   localparam int COUNT_W     = 7;
   localparam int LENGTH_W    = 7;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 56;

   localparam logic [MODE_W-1:0] MODE_INS_FIRST   = 4'd0;
   localparam logic [MODE_W-1:0] MODE_INS_LAST    = 4'd1;
   localparam logic [MODE_W-1:0] MODE_INS_AT      = 4'd2;
   localparam logic [MODE_W-1:0] MODE_DEL_FIRST   = 4'd3;
   localparam logic [MODE_W-1:0] MODE_DEL_LAST    = 4'd4;
   localparam logic [MODE_W-1:0] MODE_DEL_AT      = 4'd5;
   localparam logic [MODE_W-1:0] MODE_FIND_FIRST  = 4'd6;
   localparam logic [MODE_W-1:0] MODE_FIND_LAST   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_FIND_SECOND = 4'd8;
   localparam logic [MODE_W-1:0] MODE_COUNT       = 4'd9;
   localparam logic [MODE_W-1:0] MODE_READ        = 4'd10;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   typedef enum logic [1:0] {
      STATE_IDLE = 2'b01,
      STATE_SCAN = 2'b10
   } state_type;

   typedef struct packed {
      logic ins;
      logic del;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/plsu_cell.sv =====
// one list cell: holds an entry, shifts with its neighbors, passes the scan record on
module plsu_cell #(
   parameter int DEPTH      = plsu_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = plsu_pkg::DATA_WIDTH_DEFAULT,
   parameter int INDEX      = 0
) (
   input  logic                              clock,
   input  plsu_pkg::cell_ctrl_type           ctrl,
   input  logic [$clog2(DEPTH)-1:0]          idx,
   input  logic [DATA_WIDTH-1:0]             word,
   input  logic [$clog2(DEPTH+1)-1:0]        length,
   input  logic [DATA_WIDTH-1:0]             left_entry,
   input  logic [DATA_WIDTH-1:0]             right_entry,
   output logic [DATA_WIDTH-1:0]             entry,
   input  logic [$clog2(DEPTH+1)-1:0]        cnt_prev,
   input  logic [$clog2(DEPTH+1)-1:0]        first_prev,
   input  logic [$clog2(DEPTH+1)-1:0]        last_prev,
   input  logic [$clog2(DEPTH+1)-1:0]        second_prev,
   input  logic [DATA_WIDTH-1:0]             rdv_prev,
   output logic [$clog2(DEPTH+1)-1:0]        cnt_next,
   output logic [$clog2(DEPTH+1)-1:0]        first_next,
   output logic [$clog2(DEPTH+1)-1:0]        last_next,
   output logic [$clog2(DEPTH+1)-1:0]        second_next,
   output logic [DATA_WIDTH-1:0]             rdv_next
);

   localparam int IW = $clog2(DEPTH);
   localparam int LW = $clog2(DEPTH+1);
   localparam logic [IW-1:0] CELL_IDX = IW'(INDEX);
   localparam logic [LW-1:0] CELL_NUM = LW'(INDEX);
   localparam logic [LW-1:0] CELL_POS = LW'(INDEX + 1);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic [LW-1:0]         cnt_ff, cnt_in;
   logic [LW-1:0]         first_ff, first_in;
   logic [LW-1:0]         last_ff, last_in;
   logic [LW-1:0]         second_ff, second_in;
   logic [DATA_WIDTH-1:0] rdv_ff, rdv_in;
   logic                  match;

   assign match = (CELL_NUM < length) && (entry_ff == word);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (CELL_IDX > idx) begin
            entry_in = left_entry;
         end else if (CELL_IDX == idx) begin
            entry_in = word;
         end
      end else if (ctrl.del) begin
         if (CELL_IDX >= idx) begin
            entry_in = right_entry;
         end
      end
   end

   always_comb begin
      cnt_in    = cnt_prev + LW'(match);
      first_in  = (match && (first_prev == '0)) ? CELL_POS : first_prev;
      last_in   = match ? CELL_POS : last_prev;
      second_in = match ? last_prev : second_prev;
      rdv_in    = (CELL_IDX == idx) ? entry_ff : rdv_prev;
   end

   always_ff @(posedge clock) begin
      entry_ff  <= entry_in;
      cnt_ff    <= cnt_in;
      first_ff  <= first_in;
      last_ff   <= last_in;
      second_ff <= second_in;
      rdv_ff    <= rdv_in;
   end

   assign entry       = entry_ff;
   assign cnt_next    = cnt_ff;
   assign first_next  = first_ff;
   assign last_next   = last_ff;
   assign second_next = second_ff;
   assign rdv_next    = rdv_ff;

endmodule

// ===== rtl/core/positional_list_store_unit.sv =====
// top level of the positional list store: handshake, sequencing and the row of cells
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     req_tdata: mode, value, position
//  rsp      out  rsp_tvalid/tready     rsp_tdata: status, found_position, match_count,
//                                                 read_value, list_length
//
// inserts, deletes, unknown modes and rejected items finish in the accept cycle, result registered in the cycle after
// search, count and read scan the row of cells: the match record ripples one cell per cycle
// no item is accepted during a scan, otherwise once the result register is free or draining
// reset clears the length, state, scan counter and result valid; entries hold no reset
// a stalled result holds; a finished scan waits for the result register
module positional_list_store_unit #(
   parameter int DEPTH      = plsu_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = plsu_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // mode[3:0], value[35:4], position[42:36], zero[47:43]
   input  logic [plsu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], found_position[9:3], match_count[16:10], read_value[48:17],
   // list_length[55:49]
   output logic [plsu_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int IW  = $clog2(DEPTH);
   localparam int LW  = $clog2(DEPTH+1);
   localparam int CW  = ((LW > plsu_pkg::POS_W) ? LW : plsu_pkg::POS_W) + 1;
   localparam logic [LW-1:0] FULL_LEN = LW'(DEPTH);

   logic [plsu_pkg::MODE_W-1:0]  mode_w;
   logic [plsu_pkg::VALUE_W-1:0] value_w;
   logic [plsu_pkg::POS_W-1:0]   pos_w;

   plsu_pkg::state_type state_ff, state_in;
   logic [LW-1:0]         length_ff, length_in;
   logic [LW-1:0]         scan_ff, scan_in;
   logic [plsu_pkg::MODE_W-1:0] mode_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [IW-1:0]         idx_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [plsu_pkg::STATUS_W-1:0] status_ff;
   logic [plsu_pkg::FOUND_W-1:0]  found_ff;
   logic [plsu_pkg::COUNT_W-1:0]  count_ff;
   logic [plsu_pkg::VALUE_W-1:0]  rdv_ff;
   logic [plsu_pkg::LENGTH_W-1:0] len_out_ff;

   logic                  idle, accept, slot_free, go_scan, do_ins, do_del;
   logic                  full, empty, ins_pos_ok, pos_ok, scan_done, load_scan, load_imm;
   logic [CW-1:0]         pos_c, len_c;
   logic [IW-1:0]         pos_idx, idx_imm, cell_idx;
   logic [DATA_WIDTH-1:0] word_imm, cell_word;
   logic [plsu_pkg::STATUS_W-1:0] status_imm, status_scan;
   logic [LW-1:0]         found_scan, count_scan;
   logic [plsu_pkg::VALUE_W-1:0]  rdv_scan;
   plsu_pkg::cell_ctrl_type       ctrl;

   logic [DATA_WIDTH-1:0] entry_w  [DEPTH];
   logic [DATA_WIDTH-1:0] left_w   [DEPTH];
   logic [DATA_WIDTH-1:0] right_w  [DEPTH];
   logic [LW-1:0]         cnt_w    [DEPTH+1];
   logic [LW-1:0]         first_w  [DEPTH+1];
   logic [LW-1:0]         last_w   [DEPTH+1];
   logic [LW-1:0]         second_w [DEPTH+1];
   logic [DATA_WIDTH-1:0] rdv_w    [DEPTH+1];

   assign mode_w  = req_tdata[3:0];
   assign value_w = req_tdata[35:4];
   assign pos_w   = req_tdata[42:36];

   assign idle       = (state_ff == plsu_pkg::STATE_IDLE);
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = idle && slot_free;
   assign accept     = req_tvalid && req_tready;

   assign full       = (length_ff == FULL_LEN);
   assign empty      = (length_ff == '0);
   assign pos_c      = CW'(pos_w);
   assign len_c      = CW'(length_ff);
   assign ins_pos_ok = (pos_w != '0) && (pos_c <= (len_c + CW'(1)));
   assign pos_ok     = (pos_w != '0) && (pos_c <= len_c);
   assign pos_idx    = IW'(pos_w) - IW'(1);
   assign word_imm   = DATA_WIDTH'(signed'(value_w));

   always_comb begin
      status_imm = plsu_pkg::ST_OK;
      do_ins     = 1'b0;
      do_del     = 1'b0;
      go_scan    = 1'b0;
      idx_imm    = '0;
      case (mode_w)
         plsu_pkg::MODE_INS_FIRST, plsu_pkg::MODE_INS_LAST, plsu_pkg::MODE_INS_AT: begin
            if (full) begin
               status_imm = plsu_pkg::ST_FULL;
            end else if ((mode_w == plsu_pkg::MODE_INS_AT) && !ins_pos_ok) begin
               status_imm = plsu_pkg::ST_BADPOS;
            end else begin
               do_ins = 1'b1;
            end
            if (mode_w == plsu_pkg::MODE_INS_LAST) begin
               idx_imm = IW'(length_ff);
            end else if (mode_w == plsu_pkg::MODE_INS_AT) begin
               idx_imm = pos_idx;
            end
         end
         plsu_pkg::MODE_DEL_FIRST, plsu_pkg::MODE_DEL_LAST, plsu_pkg::MODE_DEL_AT: begin
            if (empty) begin
               status_imm = plsu_pkg::ST_EMPTY;
            end else if ((mode_w == plsu_pkg::MODE_DEL_AT) && !pos_ok) begin
               status_imm = plsu_pkg::ST_BADPOS;
            end else begin
               do_del = 1'b1;
            end
            if (mode_w == plsu_pkg::MODE_DEL_LAST) begin
               idx_imm = IW'(length_ff - LW'(1));
            end else if (mode_w == plsu_pkg::MODE_DEL_AT) begin
               idx_imm = pos_idx;
            end
         end
         plsu_pkg::MODE_FIND_FIRST, plsu_pkg::MODE_FIND_LAST,
         plsu_pkg::MODE_FIND_SECOND, plsu_pkg::MODE_COUNT: begin
            if (empty) begin
               status_imm = plsu_pkg::ST_EMPTY;
            end else begin
               go_scan = 1'b1;
            end
         end
         plsu_pkg::MODE_READ: begin
            idx_imm = pos_idx;
            if (empty) begin
               status_imm = plsu_pkg::ST_EMPTY;
            end else if (!pos_ok) begin
               status_imm = plsu_pkg::ST_BADPOS;
            end else begin
               go_scan = 1'b1;
            end
         end
         default: begin
            status_imm = plsu_pkg::ST_OK;
         end
      endcase
   end

   assign ctrl.ins  = accept && do_ins;
   assign ctrl.del  = accept && do_del;
   assign cell_idx  = idle ? idx_imm : idx_ff;
   assign cell_word = idle ? word_imm : word_ff;

   assign cnt_w[0]    = '0;
   assign first_w[0]  = '0;
   assign last_w[0]   = '0;
   assign second_w[0] = '0;
   assign rdv_w[0]    = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_left_end
         assign left_w[i] = '0;
      end else begin : g_left
         assign left_w[i] = entry_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_right_end
         assign right_w[i] = '0;
      end else begin : g_right
         assign right_w[i] = entry_w[i+1];
      end
      plsu_cell #(
         .DEPTH      (DEPTH),
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (i)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .idx         (cell_idx),
         .word        (cell_word),
         .length      (length_ff),
         .left_entry  (left_w[i]),
         .right_entry (right_w[i]),
         .entry       (entry_w[i]),
         .cnt_prev    (cnt_w[i]),
         .first_prev  (first_w[i]),
         .last_prev   (last_w[i]),
         .second_prev (second_w[i]),
         .rdv_prev    (rdv_w[i]),
         .cnt_next    (cnt_w[i+1]),
         .first_next  (first_w[i+1]),
         .last_next   (last_w[i+1]),
         .second_next (second_w[i+1]),
         .rdv_next    (rdv_w[i+1])
      );
   end

   assign scan_done = (scan_ff == FULL_LEN);
   assign load_scan = (state_ff == plsu_pkg::STATE_SCAN) && scan_done && slot_free;
   assign load_imm  = accept && !go_scan;
   assign rdv_scan  = plsu_pkg::VALUE_W'(signed'(rdv_w[DEPTH]));

   always_comb begin
      status_scan = plsu_pkg::ST_OK;
      found_scan  = '0;
      count_scan  = '0;
      case (mode_ff)
         plsu_pkg::MODE_FIND_FIRST: begin
            found_scan = first_w[DEPTH];
         end
         plsu_pkg::MODE_FIND_LAST: begin
            found_scan = last_w[DEPTH];
         end
         plsu_pkg::MODE_FIND_SECOND: begin
            found_scan = second_w[DEPTH];
         end
         plsu_pkg::MODE_COUNT: begin
            count_scan = cnt_w[DEPTH];
         end
         default: begin
            found_scan = '0;
         end
      endcase
      if ((mode_ff == plsu_pkg::MODE_COUNT) && (count_scan == '0)) begin
         status_scan = plsu_pkg::ST_NOTFOUND;
      end else if ((mode_ff inside {plsu_pkg::MODE_FIND_FIRST, plsu_pkg::MODE_FIND_LAST,
                                    plsu_pkg::MODE_FIND_SECOND}) && (found_scan == '0)) begin
         status_scan = plsu_pkg::ST_NOTFOUND;
      end
   end

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      case (state_ff)
         plsu_pkg::STATE_IDLE: begin
            scan_in = '0;
            if (accept && go_scan) begin
               state_in = plsu_pkg::STATE_SCAN;
            end
         end
         plsu_pkg::STATE_SCAN: begin
            if (!scan_done) begin
               scan_in = scan_ff + LW'(1);
            end
            if (load_scan) begin
               state_in = plsu_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = plsu_pkg::STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      length_in = length_ff;
      if (ctrl.ins) begin
         length_in = length_ff + LW'(1);
      end else if (ctrl.del) begin
         length_in = length_ff - LW'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_imm || load_scan) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= plsu_pkg::STATE_IDLE;
         scan_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= mode_w;
         word_ff <= word_imm;
         idx_ff  <= idx_imm;
      end
      if (load_imm) begin
         status_ff  <= status_imm;
         found_ff   <= '0;
         count_ff   <= '0;
         rdv_ff     <= '0;
         len_out_ff <= plsu_pkg::LENGTH_W'(length_in);
      end else if (load_scan) begin
         status_ff  <= status_scan;
         found_ff   <= plsu_pkg::FOUND_W'(found_scan);
         count_ff   <= plsu_pkg::COUNT_W'(count_scan);
         rdv_ff     <= (mode_ff == plsu_pkg::MODE_READ) ? rdv_scan : '0;
         len_out_ff <= plsu_pkg::LENGTH_W'(length_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {len_out_ff, rdv_ff, count_ff, found_ff, status_ff};

endmodule

// ===== test/list_store_checker.sv =====
// channel monitor for the positional list store: keeps a shadow list, predicts and compares
module list_store_checker #(
   parameter int DEPTH = plsu_pkg::DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [plsu_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [plsu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                               error_count,
   output int                               results_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import plsu_pkg::*;

   // declared msb first, so status lands in the low bits as on rsp_tdata
   typedef struct packed {
      logic [LENGTH_W-1:0] list_len;
      logic [VALUE_W-1:0]  read_word;
      logic [COUNT_W-1:0]  hits;
      logic [FOUND_W-1:0]  found_pos;
      logic [STATUS_W-1:0] status;
   } outcome_type;

   logic [VALUE_W-1:0] shadow_words [DEPTH];
   int                 shadow_len = 0;
   outcome_type        outcome_q [$];
   int                 mismatches = 0;

   assign error_count = mismatches;

   function automatic void insert_word(int idx, logic [VALUE_W-1:0] word);
      for (int i = shadow_len; i > idx; i--) shadow_words[i] = shadow_words[i-1];
      shadow_words[idx] = word;
      shadow_len++;
   endfunction

   function automatic void remove_word(int idx);
      for (int i = idx; i < shadow_len - 1; i++) shadow_words[i] = shadow_words[i+1];
      shadow_len--;
   endfunction

   function automatic outcome_type apply_list_op(logic [MODE_W-1:0] mode,
                                                 logic [VALUE_W-1:0] word,
                                                 logic [POS_W-1:0] pos);
      outcome_type res;
      int first, last, prev, hits;
      res = '0;
      first = 0;
      last = 0;
      prev = 0;
      hits = 0;
      case (mode)
         MODE_INS_FIRST, MODE_INS_LAST, MODE_INS_AT: begin
            if (shadow_len >= DEPTH) res.status = ST_FULL;
            else if (mode == MODE_INS_FIRST) insert_word(0, word);
            else if (mode == MODE_INS_LAST) insert_word(shadow_len, word);
            else if (pos == 0 || int'(pos) > shadow_len + 1) res.status = ST_BADPOS;
            else insert_word(int'(pos) - 1, word);
         end
         MODE_DEL_FIRST, MODE_DEL_LAST, MODE_DEL_AT: begin
            if (shadow_len == 0) res.status = ST_EMPTY;
            else if (mode == MODE_DEL_FIRST) remove_word(0);
            else if (mode == MODE_DEL_LAST) remove_word(shadow_len - 1);
            else if (pos == 0 || int'(pos) > shadow_len) res.status = ST_BADPOS;
            else remove_word(int'(pos) - 1);
         end
         MODE_FIND_FIRST, MODE_FIND_LAST, MODE_FIND_SECOND, MODE_COUNT: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               for (int i = 0; i < shadow_len; i++) begin
                  if (shadow_words[i] == word) begin
                     if (first == 0) first = i + 1;
                     prev = last;
                     last = i + 1;
                     hits++;
                  end
               end
               case (mode)
                  MODE_FIND_FIRST:  res.found_pos = FOUND_W'(first);
                  MODE_FIND_LAST:   res.found_pos = FOUND_W'(last);
                  MODE_FIND_SECOND: res.found_pos = FOUND_W'(prev);
                  default:          res.hits = COUNT_W'(hits);
               endcase
               if (mode == MODE_COUNT ? hits == 0 : res.found_pos == 0) res.status = ST_NOTFOUND;
            end
         end
         MODE_READ: begin
            if (shadow_len == 0) res.status = ST_EMPTY;
            else if (pos == 0 || int'(pos) > shadow_len) res.status = ST_BADPOS;
            else res.read_word = shadow_words[int'(pos) - 1];
         end
         default: ;
      endcase
      res.list_len = LENGTH_W'(shadow_len);
      return res;
   endfunction

   task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t ns mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want, got;
      if (reset) begin
         shadow_len = 0;
         outcome_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            outcome_q.push_back(apply_list_op(req_tdata[MODE_W-1:0],
                                              req_tdata[MODE_W +: VALUE_W],
                                              req_tdata[MODE_W+VALUE_W +: POS_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = outcome_type'(rsp_tdata);
            if (outcome_q.size() == 0) begin
               $display("%0t ns result transfer with none outstanding: %0h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               check_field("status", want.status, got.status);
               check_field("found_position", want.found_pos, got.found_pos);
               check_field("match_count", want.hits, got.hits);
               check_field("read_value", want.read_word, got.read_word);
               check_field("list_length", want.list_len, got.list_len);
            end
         end
      end
      results_pending <= outcome_q.size();
   end

endmodule

// ===== test/tb.sv =====
// top of the positional list store testbench: clock, reset, stimulus, watchdog and verdict
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import plsu_pkg::*;

   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES  = 200;
   localparam int STALL_LIMIT  = 5000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   logic steady      = 1'b0;
   logic hold_done   = 1'b0;
   int   hold_left   = 0;
   int   items_sent  = 0;
   int   idle_cycles = 0;
   int   error_count;
   int   results_pending;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   positional_list_store_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   list_store_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   // receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && items_sent >= 300) begin
         hold_done  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 27);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic offer_op(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] word,
                           input logic [POS_W-1:0] pos);
      while (!steady && $urandom_range(99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-MODE_W-VALUE_W-POS_W){1'b0}}, pos, word, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // a small pool of words keeps searches hitting
   function automatic logic [VALUE_W-1:0] pick_word();
      logic [VALUE_W-1:0] pool [6] = '{32'h0, 32'h1, 32'hffff_ffff, 32'd42,
                                       32'h7fff_ffff, 32'h8000_0000};
      return $urandom_range(1) ? pool[$urandom_range(5)] : $urandom();
   endfunction

   function automatic logic [POS_W-1:0] pick_pos();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return POS_W'($urandom_range(20));
      if (roll < 90) return POS_W'($urandom_range(DEPTH_DEFAULT + 2));
      return POS_W'($urandom_range(127));
   endfunction

   initial begin
      logic [MODE_W-1:0] mode;
      int                roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list
      offer_op(MODE_DEL_FIRST, 32'h0, 7'd0);
      offer_op(MODE_DEL_LAST, 32'h0, 7'd0);
      offer_op(MODE_DEL_AT, 32'h0, 7'd1);
      offer_op(MODE_FIND_FIRST, 32'h0, 7'd0);
      offer_op(MODE_COUNT, 32'h0, 7'd0);
      offer_op(MODE_READ, 32'h0, 7'd1);
      offer_op(MODE_INS_AT, 32'h5, 7'd0);
      offer_op(MODE_INS_AT, 32'h5, 7'd2);
      // insert at position one on an empty list appends
      offer_op(MODE_INS_AT, 32'h7fff_ffff, 7'd1);
      offer_op(MODE_INS_FIRST, 32'h8000_0000, 7'd0);
      offer_op(MODE_INS_LAST, 32'hffff_ffff, 7'd0);
      offer_op(MODE_INS_AT, 32'h5, 7'd4);
      offer_op(MODE_INS_AT, 32'h5, 7'd2);
      offer_op(MODE_READ, 32'h0, 7'd0);
      offer_op(MODE_READ, 32'h0, 7'd6);
      offer_op(MODE_READ, 32'h0, 7'd1);
      offer_op(MODE_FIND_FIRST, 32'h5, 7'd0);
      offer_op(MODE_FIND_LAST, 32'h5, 7'd0);
      offer_op(MODE_FIND_SECOND, 32'h5, 7'd0);
      offer_op(MODE_FIND_SECOND, 32'hffff_ffff, 7'd0);
      offer_op(MODE_COUNT, 32'h5, 7'd0);
      offer_op(MODE_COUNT, 32'h9, 7'd0);
      offer_op(MODE_DEL_AT, 32'h0, 7'd0);
      offer_op(MODE_DEL_AT, 32'h0, 7'd127);
      offer_op(MODE_DEL_AT, 32'h0, 7'd3);
      offer_op({MODE_W{1'b1}}, 32'hffff_ffff, 7'd127);

      // phases: fill to full, mixed, drain to empty, mixed
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady <= (n >= 700 && n < 900);
         roll = $urandom_range(99);
         case ((n / 130) % 4)
            0: mode = MODE_W'(roll < 80 ? $urandom_range(MODE_INS_AT, MODE_INS_FIRST) :
                              roll < 95 ? $urandom_range(MODE_READ, MODE_FIND_FIRST) :
                                          $urandom_range({MODE_W{1'b1}}, 0));
            2: mode = MODE_W'(roll < 80 ? $urandom_range(MODE_DEL_AT, MODE_DEL_FIRST) :
                              roll < 95 ? $urandom_range(MODE_READ, MODE_FIND_FIRST) :
                                          $urandom_range({MODE_W{1'b1}}, 0));
            default: mode = MODE_W'(roll < 95 ?
                                    $urandom_range(MODE_READ, MODE_INS_FIRST) :
                                    $urandom_range({MODE_W{1'b1}}, MODE_READ + 1));
         endcase
         offer_op(mode, pick_word(), pick_pos());
      end

      req_tvalid <= 1'b0;
      steady     <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (DEPTH_DEFAULT + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/plsu_pkg.sv
rtl/core/plsu_cell.sv
rtl/core/positional_list_store_unit.sv
test/list_store_checker.sv
test/tb.sv
